### rtl/qhadam_param_update_top_assert.svh
// ----------------------------------------------------------------------------
// QHAdam update assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QHADAM_PARAM_UPDATE_TOP_ASSERT_SVH
`define QHADAM_PARAM_UPDATE_TOP_ASSERT_SVH
`ifndef SYNTH
`define QHA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qhadam assertion failed");
`define QHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qhadam assertion failed");
`else
`define QHA_ASSERT_IMPL(lbl, ante, cons)
`define QHA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/qha_pkg.sv
// ----------------------------------------------------------------------------
// QHAdam update package
// Constants, register codes and rounding helpers shared by the block.
// ----------------------------------------------------------------------------
package qha_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 25;

	localparam int SQ_STAGES = 16;  // square root: 2 root bits per stage
	localparam int SQ_PER    = 2;
	localparam int DV_STAGES = 11;  // divider: 3 quotient bits per stage
	localparam int DV_PER    = 3;
	localparam int NSTAGES   = 6 + SQ_STAGES + 1 + DV_STAGES + 3;

	localparam logic [24:0] LR_ONE   = 25'h1000000;
	localparam logic [16:0] COEF_ONE = 17'h10000;

	localparam logic [24:0] LR_RST  = 25'd16777;
	localparam logic [16:0] WD_RST  = 17'd0;
	localparam logic [16:0] B1_RST  = 17'd58982;
	localparam logic [16:0] B2_RST  = 17'd65470;
	localparam logic [16:0] N1_RST  = 17'd45875;
	localparam logic [16:0] N2_RST  = 17'd65536;
	localparam logic [15:0] EPS_RST = 16'd1;

	localparam logic signed [65:0] SMAX66 = 66'sh7FFFFFFF;
	localparam logic signed [65:0] SMIN66 = -SMAX66 - 66'sd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LR  = 3'd0,
		REG_WD  = 3'd1,
		REG_B1  = 3'd2,
		REG_B2  = 3'd3,
		REG_N1  = 3'd4,
		REG_N2  = 3'd5,
		REG_EPS = 3'd6
	} cfg_reg_t;

	function automatic logic [16:0] coef_clamp(input logic [16:0] c);
		return (c > COEF_ONE) ? COEF_ONE : c;
	endfunction

	// Round to nearest, ties away from zero, on the magnitude.
	function automatic logic [65:0] urnd(input logic [65:0] x, input int s);
		return (x + (66'd1 << (s - 1))) >> s;
	endfunction

	function automatic logic signed [65:0] srnd(input logic signed [65:0] x, input int s);
		logic [65:0] mag;
		logic [65:0] r;
		mag = x[65] ? 66'(-x) : 66'(x);
		r = urnd(mag, s);
		return x[65] ? -$signed(r) : $signed(r);
	endfunction

	// Returns {overflow, value} saturated to signed 32 bits.
	function automatic logic [32:0] ssat32(input logic signed [65:0] x);
		if (x > SMAX66)
			return {1'b1, 32'h7FFFFFFF};
		if (x < SMIN66)
			return {1'b1, 32'h80000000};
		return {1'b0, x[31:0]};
	endfunction

endpackage

### rtl/qha_in_if.sv
// ----------------------------------------------------------------------------
// QHAdam input channel
// Valid/ready channel carrying one parameter element and its moments.
// ----------------------------------------------------------------------------
interface qha_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] param_value;
	logic signed [31:0] gradient;
	logic signed [31:0] first_moment;
	logic        [31:0] second_moment;

	modport source (output valid, output param_value, output gradient,
		output first_moment, output second_moment, input ready);
	modport sink (input valid, input param_value, input gradient,
		input first_moment, input second_moment, output ready);
endinterface

### rtl/qha_out_if.sv
// ----------------------------------------------------------------------------
// QHAdam output channel
// Valid/ready channel carrying the updated element and its flag.
// ----------------------------------------------------------------------------
interface qha_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] new_param;
	logic signed [31:0] new_first_moment;
	logic        [31:0] new_second_moment;
	logic               saturated;

	modport source (output valid, output new_param, output new_first_moment,
		output new_second_moment, output saturated, input ready);
	modport sink (input valid, input new_param, input new_first_moment,
		input new_second_moment, input saturated, output ready);
endinterface

### rtl/qhadam_param_update_top.sv
// ----------------------------------------------------------------------------
// QHAdam parameter update
// Channel  | Dir | Payload
// in_ch    | in  | param_value, gradient, first_moment, second_moment
// out_ch   | out | new_param, new_first_moment, new_second_moment, saturated
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One item per cycle while the output is taken; the depth is set by the square root
// (16 stages, two root bits each) and the divider (11 stages, three quotient
// bits each). Reset loads the register defaults and empties the pipeline.
// When the output item is held, the whole pipeline holds with it.
// ----------------------------------------------------------------------------
module qhadam_param_update_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qha_pkg::CFG_DATA_W-1:0] cfg_data,
	qha_in_if.sink                         in_ch,
	qha_out_if.source                      out_ch
);
	import qha_pkg::*;

	logic [24:0] lr_q;
	logic [16:0] wd_q, b1_q, b2_q, n1_q, n2_q;
	logic [15:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LR_RST;
			wd_q  <= WD_RST;
			b1_q  <= B1_RST;
			b2_q  <= B2_RST;
			n1_q  <= N1_RST;
			n2_q  <= N2_RST;
			eps_q <= EPS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LR:  lr_q  <= cfg_data;
				REG_WD:  wd_q  <= cfg_data[16:0];
				REG_B1:  b1_q  <= cfg_data[16:0];
				REG_B2:  b2_q  <= cfg_data[16:0];
				REG_N1:  n1_q  <= cfg_data[16:0];
				REG_N2:  n2_q  <= cfg_data[16:0];
				REG_EPS: eps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [24:0] lr_c;
	logic [16:0] wd_c, b1_c, b2_c, n1_c, n2_c, b1m, b2m, n1m, n2m;

	assign lr_c = (lr_q > LR_ONE) ? LR_ONE : lr_q;
	assign wd_c = coef_clamp(wd_q);
	assign b1_c = coef_clamp(b1_q);
	assign b2_c = coef_clamp(b2_q);
	assign n1_c = coef_clamp(n1_q);
	assign n2_c = coef_clamp(n2_q);
	assign b1m  = COEF_ONE - b1_c;
	assign b2m  = COEF_ONE - b2_c;
	assign n1m  = COEF_ONE - n1_c;
	assign n2m  = COEF_ONE - n2_c;

	// Pipeline control: every stage moves when the output register is free.
	logic               adv;
	logic [NSTAGES-1:0] vld_q;

	assign adv         = !vld_q[NSTAGES-1] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[NSTAGES-2:0], in_ch.valid};
	end

	// Stage 1: products of the inputs.
	logic        [31:0] gmag;
	logic signed [31:0] p_s1, g_s1;
	logic        [41:0] wdp_s1;
	logic        [63:0] gg_s1;
	logic signed [49:0] mb_s1, mg_s1;
	logic        [48:0] vb_s1;

	assign gmag = in_ch.gradient[31] ? 32'(-in_ch.gradient) : 32'(in_ch.gradient);

	// Stage 2: decay factor, squared gradient and new first moment.
	logic        [65:0] lrwd_w;
	logic        [32:0] msat_w;
	logic signed [31:0] p_s2, g_s2, m_new_s2;
	logic        [24:0] factor_s2;
	logic        [46:0] gsq_s2;
	logic        [48:0] vb_s2;
	logic               flag_s2;

	assign lrwd_w = urnd(66'(wdp_s1), 16);
	assign msat_w = ssat32(srnd(66'(mb_s1) + 66'(mg_s1), 16));

	// Stage 3: second round of products.
	logic signed [57:0] pf_s3;
	logic        [63:0] vg_s3;
	logic signed [49:0] nga_s3, nmb_s3;
	logic        [48:0] vb_s3;
	logic        [46:0] gsq_s3;
	logic signed [31:0] m_new_s3;
	logic               flag_s3;

	// Stage 4: decayed parameter, new second moment, numerator.
	logic        [65:0] vsum_w;
	logic signed [33:0] p1_s4;
	logic        [31:0] v_new_s4;
	logic signed [32:0] num_s4;
	logic        [46:0] gsq_s4;
	logic signed [31:0] m_new_s4;
	logic               flag_s4;

	assign vsum_w = urnd(66'(vb_s3) + 66'(vg_s3), 16);

	// Stage 5: denominator products.
	logic        [48:0] dv_s5;
	logic        [63:0] dg_s5;
	logic signed [33:0] p1_s5;
	logic signed [32:0] num_s5;
	logic signed [31:0] m_new_s5;
	logic        [31:0] v_new_s5;
	logic               flag_s5;

	// Stage 6: radicand and numerator magnitude.
	logic        [65:0] d_w;
	logic        [63:0] x_s6;
	logic signed [33:0] p1_s6;
	logic               neg_s6;
	logic        [31:0] nmag_s6;
	logic signed [31:0] m_new_s6;
	logic        [31:0] v_new_s6;
	logic               flag_s6;

	assign d_w = urnd(66'(dv_s5) + 66'(dg_s5), 16);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1   <= in_ch.param_value;
			g_s1   <= in_ch.gradient;
			wdp_s1 <= lr_c * wd_c;
			gg_s1  <= gmag * gmag;
			mb_s1  <= $signed({1'b0, b1_c}) * in_ch.first_moment;
			mg_s1  <= $signed({1'b0, b1m}) * in_ch.gradient;
			vb_s1  <= b2_c * in_ch.second_moment;

			p_s2      <= p_s1;
			g_s2      <= g_s1;
			factor_s2 <= LR_ONE - lrwd_w[24:0];
			gsq_s2    <= 47'(urnd(66'(gg_s1), 16));
			m_new_s2  <= msat_w[31:0];
			flag_s2   <= msat_w[32];
			vb_s2     <= vb_s1;

			pf_s3    <= p_s2 * $signed({1'b0, factor_s2});
			vg_s3    <= b2m * gsq_s2;
			nga_s3   <= $signed({1'b0, n1m}) * g_s2;
			nmb_s3   <= $signed({1'b0, n1_c}) * m_new_s2;
			vb_s3    <= vb_s2;
			gsq_s3   <= gsq_s2;
			m_new_s3 <= m_new_s2;
			flag_s3  <= flag_s2;

			p1_s4    <= 34'(srnd(66'(pf_s3), 24));
			v_new_s4 <= (vsum_w > 66'h0FFFFFFFF) ? 32'hFFFFFFFF : vsum_w[31:0];
			num_s4   <= 33'(srnd(66'(nga_s3) + 66'(nmb_s3), 16));
			gsq_s4   <= gsq_s3;
			m_new_s4 <= m_new_s3;
			flag_s4  <= flag_s3 || (vsum_w > 66'h0FFFFFFFF);

			dv_s5    <= n2_c * v_new_s4;
			dg_s5    <= n2m * gsq_s4;
			p1_s5    <= p1_s4;
			num_s5   <= num_s4;
			m_new_s5 <= m_new_s4;
			v_new_s5 <= v_new_s4;
			flag_s5  <= flag_s4;

			x_s6     <= {d_w[47:0], 16'd0};
			p1_s6    <= p1_s5;
			neg_s6   <= num_s5[32];
			nmag_s6  <= num_s5[32] ? 32'(-num_s5) : 32'(num_s5);
			m_new_s6 <= m_new_s5;
			v_new_s6 <= v_new_s5;
			flag_s6  <= flag_s5;
		end
	end

	// Square root stages: restoring digit recurrence, two root bits a stage.
	logic        [63:0] sq_x_s7    [SQ_STAGES];
	logic        [33:0] sq_rem_s7  [SQ_STAGES];
	logic        [31:0] sq_root_s7 [SQ_STAGES];
	logic signed [33:0] sq_p1_s7   [SQ_STAGES];
	logic               sq_neg_s7  [SQ_STAGES];
	logic        [31:0] sq_nmag_s7 [SQ_STAGES];
	logic signed [31:0] sq_m_s7    [SQ_STAGES];
	logic        [31:0] sq_v_s7    [SQ_STAGES];
	logic               sq_flag_s7 [SQ_STAGES];
	logic        [63:0] sq_x_nx    [SQ_STAGES];
	logic        [33:0] sq_rem_nx  [SQ_STAGES];
	logic        [31:0] sq_root_nx [SQ_STAGES];

	always_comb begin
		logic [63:0] x;
		logic [33:0] rem;
		logic [34:0] rem_w;
		logic [34:0] trial;
		logic [31:0] root;
		for (int k = 0; k < SQ_STAGES; k++) begin
			if (k == 0) begin
				x    = x_s6;
				rem  = '0;
				root = '0;
			end else begin
				x    = sq_x_s7[k-1];
				rem  = sq_rem_s7[k-1];
				root = sq_root_s7[k-1];
			end
			for (int j = 0; j < SQ_PER; j++) begin
				rem_w = {rem[32:0], x[63:62]};
				trial = {1'b0, root, 2'b01};
				x     = x << 2;
				if (rem_w >= trial) begin
					rem_w = rem_w - trial;
					root  = {root[30:0], 1'b1};
				end else begin
					root = {root[30:0], 1'b0};
				end
				rem = rem_w[33:0];
			end
			sq_x_nx[k]    = x;
			sq_rem_nx[k]  = rem;
			sq_root_nx[k] = root;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < SQ_STAGES; k++) begin
				sq_x_s7[k]    <= sq_x_nx[k];
				sq_rem_s7[k]  <= sq_rem_nx[k];
				sq_root_s7[k] <= sq_root_nx[k];
				if (k == 0) begin
					sq_p1_s7[k]   <= p1_s6;
					sq_neg_s7[k]  <= neg_s6;
					sq_nmag_s7[k] <= nmag_s6;
					sq_m_s7[k]    <= m_new_s6;
					sq_v_s7[k]    <= v_new_s6;
					sq_flag_s7[k] <= flag_s6;
				end else begin
					sq_p1_s7[k]   <= sq_p1_s7[k-1];
					sq_neg_s7[k]  <= sq_neg_s7[k-1];
					sq_nmag_s7[k] <= sq_nmag_s7[k-1];
					sq_m_s7[k]    <= sq_m_s7[k-1];
					sq_v_s7[k]    <= sq_v_s7[k-1];
					sq_flag_s7[k] <= sq_flag_s7[k-1];
				end
			end
		end
	end

	// Stage 23: denominator and divider operands.
	// The quotient is (2*num*2^16 + den) / (2*den), which rounds half away.
	logic        [32:0] den_w;
	logic        [32:0] den_fix_w;
	logic        [49:0] dvn_w;
	logic        [49:0] dvn_s23;
	logic        [33:0] dvd_s23;
	logic               ovf_s23;
	logic signed [33:0] p1_s23;
	logic               neg_s23;
	logic signed [31:0] m_s23;
	logic        [31:0] v_s23;
	logic               flag_s23;

	assign den_w     = {1'b0, sq_root_s7[SQ_STAGES-1]} + {17'd0, eps_q};
	assign den_fix_w = (den_w == 33'd0) ? 33'd1 : den_w;
	assign dvn_w     = {1'b0, sq_nmag_s7[SQ_STAGES-1], 17'd0} + {17'd0, den_fix_w};

	always_ff @(posedge clk) begin
		if (adv) begin
			dvn_s23  <= dvn_w;
			dvd_s23  <= {den_fix_w, 1'b0};
			// A quotient of 2^33 or more saturates whatever the low bits.
			ovf_s23  <= {17'd0, dvn_w[49:33]} >= {den_fix_w, 1'b0};
			p1_s23   <= sq_p1_s7[SQ_STAGES-1];
			neg_s23  <= sq_neg_s7[SQ_STAGES-1];
			m_s23    <= sq_m_s7[SQ_STAGES-1];
			v_s23    <= sq_v_s7[SQ_STAGES-1];
			flag_s23 <= sq_flag_s7[SQ_STAGES-1];
		end
	end

	// Divider stages: restoring division, three quotient bits a stage.
	logic        [49:0] dv_r_s24    [DV_STAGES];
	logic        [33:0] dv_d_s24    [DV_STAGES];
	logic        [32:0] dv_q_s24    [DV_STAGES];
	logic               dv_ovf_s24  [DV_STAGES];
	logic signed [33:0] dv_p1_s24   [DV_STAGES];
	logic               dv_neg_s24  [DV_STAGES];
	logic signed [31:0] dv_m_s24    [DV_STAGES];
	logic        [31:0] dv_v_s24    [DV_STAGES];
	logic               dv_flag_s24 [DV_STAGES];
	logic        [49:0] dv_r_nx     [DV_STAGES];
	logic        [32:0] dv_q_nx     [DV_STAGES];

	always_comb begin
		logic [66:0] r;
		logic [66:0] sub;
		logic [33:0] d;
		logic [32:0] q;
		int          bi;
		for (int k = 0; k < DV_STAGES; k++) begin
			if (k == 0) begin
				r = {17'd0, dvn_s23};
				d = dvd_s23;
				q = '0;
			end else begin
				r = {17'd0, dv_r_s24[k-1]};
				d = dv_d_s24[k-1];
				q = dv_q_s24[k-1];
			end
			for (int j = 0; j < DV_PER; j++) begin
				bi  = 32 - (k * DV_PER + j);
				sub = {33'd0, d} << bi;
				if (r >= sub) begin
					r     = r - sub;
					q[bi] = 1'b1;
				end
			end
			dv_r_nx[k] = r[49:0];
			dv_q_nx[k] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DV_STAGES; k++) begin
				dv_r_s24[k] <= dv_r_nx[k];
				dv_q_s24[k] <= dv_q_nx[k];
				if (k == 0) begin
					dv_d_s24[k]    <= dvd_s23;
					dv_ovf_s24[k]  <= ovf_s23;
					dv_p1_s24[k]   <= p1_s23;
					dv_neg_s24[k]  <= neg_s23;
					dv_m_s24[k]    <= m_s23;
					dv_v_s24[k]    <= v_s23;
					dv_flag_s24[k] <= flag_s23;
				end else begin
					dv_d_s24[k]    <= dv_d_s24[k-1];
					dv_ovf_s24[k]  <= dv_ovf_s24[k-1];
					dv_p1_s24[k]   <= dv_p1_s24[k-1];
					dv_neg_s24[k]  <= dv_neg_s24[k-1];
					dv_m_s24[k]    <= dv_m_s24[k-1];
					dv_v_s24[k]    <= dv_v_s24[k-1];
					dv_flag_s24[k] <= dv_flag_s24[k-1];
				end
			end
		end
	end

	// Stage 35: signed, saturated quotient.
	logic        [32:0] qmag_w;
	logic               qbig_w;
	logic signed [31:0] q_s35;
	logic signed [33:0] p1_s35;
	logic signed [31:0] m_s35;
	logic        [31:0] v_s35;
	logic               flag_s35;

	assign qmag_w = dv_q_s24[DV_STAGES-1];
	assign qbig_w = dv_ovf_s24[DV_STAGES-1] ||
		(dv_neg_s24[DV_STAGES-1] ? (qmag_w > 33'h080000000) : (qmag_w >= 33'h080000000));

	// Stage 36: step product.
	logic signed [57:0] up_s36;
	logic signed [33:0] p1_s36;
	logic signed [31:0] m_s36;
	logic        [31:0] v_s36;
	logic               flag_s36;

	// Stage 37: output register.
	logic        [32:0] psat_w;
	logic signed [31:0] p_out_s37, m_out_s37;
	logic        [31:0] v_out_s37;
	logic               flag_out_s37;

	assign psat_w = ssat32(66'(p1_s36) - srnd(66'(up_s36), 24));

	always_ff @(posedge clk) begin
		if (adv) begin
			if (qbig_w)
				q_s35 <= dv_neg_s24[DV_STAGES-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
			else
				q_s35 <= dv_neg_s24[DV_STAGES-1] ? 32'(-qmag_w) : qmag_w[31:0];
			p1_s35   <= dv_p1_s24[DV_STAGES-1];
			m_s35    <= dv_m_s24[DV_STAGES-1];
			v_s35    <= dv_v_s24[DV_STAGES-1];
			flag_s35 <= dv_flag_s24[DV_STAGES-1] || qbig_w;

			up_s36   <= q_s35 * $signed({1'b0, lr_c});
			p1_s36   <= p1_s35;
			m_s36    <= m_s35;
			v_s36    <= v_s35;
			flag_s36 <= flag_s35;

			p_out_s37    <= psat_w[31:0];
			m_out_s37    <= m_s36;
			v_out_s37    <= v_s36;
			flag_out_s37 <= flag_s36 || psat_w[32];
		end
	end

	assign out_ch.valid             = vld_q[NSTAGES-1];
	assign out_ch.new_param         = p_out_s37;
	assign out_ch.new_first_moment  = m_out_s37;
	assign out_ch.new_second_moment = v_out_s37;
	assign out_ch.saturated         = flag_out_s37;

`include "qhadam_param_update_top_assert.svh"

	`QHA_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, vld_q[0])
	`QHA_ASSERT_NEXT(a_last_reaches_out, adv && vld_q[NSTAGES-2], out_ch.valid)
	`QHA_ASSERT_IMPL(a_den_nonzero, vld_q[6 + SQ_STAGES], dvd_s23 != 34'd0)

endmodule
